// ===== sv/windowed_line_fit_core_assert.svh =====
// Assertion macros for the top file that checks this block.
// Each macro uses the clk and rst signals of the module that expands it.
`ifndef WINDOWED_LINE_FIT_CORE_ASSERT_SVH
`define WINDOWED_LINE_FIT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wlf_pkg.sv =====
`timescale 1ns / 1ps
package wlf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 13;
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 13'd4096;
  localparam int SX_W        = 29;
  localparam int SXX_W       = 44;
  localparam int SY_W        = 29;
  localparam int SXY_W       = 45;
  localparam int FRAC_BITS   = 16;
  localparam int OPER_W      = 64;
  localparam int PROD_W      = 96;
  localparam int QUO_W       = 44;
  localparam int DIV_W       = 112;
  localparam int QCNT_W      = 6;
  localparam int SLOPE_W     = 37;
  localparam int OFFS_W      = 26;
  localparam int OFFSET_SHIFT = 8;
  localparam logic signed [OPER_W-1:0] SLOPE_LIMIT = 64'sd1000000;
  localparam logic signed [OPER_W-1:0] MEAN_SAT = 64'sd256 <<< FRAC_BITS;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [1:0] REG_WINDOW_START = 2'd1;
  localparam logic [1:0] REG_WINDOW_END   = 2'd2;

  // Product sequence of the fit.
  localparam logic [2:0] STEP_N_SXY   = 3'd0;
  localparam logic [2:0] STEP_SX_SY   = 3'd1;
  localparam logic [2:0] STEP_SXX_SY  = 3'd2;
  localparam logic [2:0] STEP_SX_SXY  = 3'd3;
  localparam logic [2:0] STEP_N_SXX   = 3'd4;
  localparam logic [2:0] STEP_SX_SX   = 3'd5;
  localparam logic [2:0] STEP_LIMIT   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_BAD_WINDOW    = 2'd1,
    ST_OUT_OF_LIMITS = 2'd2
  } fit_status_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL_GO, B_MUL_WAIT, B_CHECK, B_DIV_GO, B_DIV_WAIT, B_FIN
  } back_state_t;

  typedef struct packed {
    logic                     avg;
    logic                     bad;
    logic [CNT_W-1:0]         n;
    logic signed [SX_W-1:0]   sum_x;
    logic signed [SXX_W-1:0]  sum_xx;
    logic signed [SY_W-1:0]   sum_y;
    logic signed [SXY_W-1:0]  sum_xy;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [PROD_W-1:0] abs96(input logic signed [PROD_W-1:0] v);
    abs96 = v[PROD_W-1] ? -v : v;
  endfunction

endpackage

// ===== sv/wlf_if.sv =====
`timescale 1ns / 1ps
interface wlf_sample_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic        last_sample;
  modport source (output valid, x_value, y_value, last_sample, input ready);
  modport sink   (input valid, x_value, y_value, last_sample, output ready);
endinterface

interface wlf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [36:0] slope;
  logic signed [25:0] offset;
  modport source (output valid, status, slope, offset, input ready);
  modport sink   (input valid, status, slope, offset, output ready);
endinterface

// ===== sv/wlf_front.sv =====
`timescale 1ns / 1ps
module wlf_front (
  input  logic                          clk,
  input  logic                          rst,
  wlf_sample_if.sink                    smp,
  input  logic                          fit_mode,
  input  logic [wlf_pkg::IDX_W-1:0]     window_start,
  input  logic [wlf_pkg::IDX_W-1:0]     window_end,
  input  wlf_pkg::q_stat_t              q_st,
  output logic                          q_push,
  output wlf_pkg::job_t                 q_job
);

  logic [wlf_pkg::CNT_W-1:0] sample_count, sample_count_next;
  logic signed [wlf_pkg::SX_W-1:0]  sum_x, sum_x_next;
  logic signed [wlf_pkg::SXX_W-1:0] sum_xx, sum_xx_next;
  logic signed [wlf_pkg::SY_W-1:0]  sum_y, sum_y_next;
  logic signed [wlf_pkg::SXY_W-1:0] sum_xy, sum_xy_next;
  logic signed [31:0] xx_prod, xy_prod;
  logic accept, in_window;

  assign smp.ready = !q_st.full;
  assign accept    = smp.valid && smp.ready;
  assign xx_prod   = smp.x_value * smp.x_value;
  assign xy_prod   = smp.x_value * smp.y_value;
  assign in_window = (sample_count >= wlf_pkg::CNT_W'(window_start)) &&
                     (sample_count <= wlf_pkg::CNT_W'(window_end));

  always_comb begin
    sample_count_next = (sample_count < wlf_pkg::MAX_SAMPLES) ?
                        sample_count + 1'b1 : sample_count;
    sum_x_next  = sum_x;
    sum_xx_next = sum_xx;
    sum_y_next  = sum_y;
    sum_xy_next = sum_xy;
    if (in_window) begin
      sum_x_next  = sum_x  + wlf_pkg::SX_W'(smp.x_value);
      sum_xx_next = sum_xx + wlf_pkg::SXX_W'(xx_prod);
      sum_y_next  = sum_y  + wlf_pkg::SY_W'(smp.y_value);
      sum_xy_next = sum_xy + wlf_pkg::SXY_W'(xy_prod);
    end
  end

  // The closing sample hands the finished sums to the back part.
  assign q_push       = accept && smp.last_sample;
  assign q_job.avg    = fit_mode;
  assign q_job.bad    = (wlf_pkg::CNT_W'(window_end) >= sample_count_next) ||
                        (wlf_pkg::CNT_W'(window_end) <
                         wlf_pkg::CNT_W'(window_start) + 13'd2);
  assign q_job.n      = wlf_pkg::CNT_W'(window_end) - wlf_pkg::CNT_W'(window_start) + 13'd1;
  assign q_job.sum_x  = sum_x_next;
  assign q_job.sum_xx = sum_xx_next;
  assign q_job.sum_y  = sum_y_next;
  assign q_job.sum_xy = sum_xy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sum_x        <= '0;
      sum_xx       <= '0;
      sum_y        <= '0;
      sum_xy       <= '0;
    end else if (accept) begin
      if (smp.last_sample) begin
        sample_count <= '0;
        sum_x        <= '0;
        sum_xx       <= '0;
        sum_y        <= '0;
        sum_xy       <= '0;
      end else begin
        sample_count <= sample_count_next;
        sum_x        <= sum_x_next;
        sum_xx       <= sum_xx_next;
        sum_y        <= sum_y_next;
        sum_xy       <= sum_xy_next;
      end
    end
  end

endmodule

// ===== sv/wlf_queue.sv =====
`timescale 1ns / 1ps
module wlf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wlf_pkg::job_t     push_job,
  input  logic              pop,
  output wlf_pkg::job_t     head,
  output wlf_pkg::q_stat_t  q_st
);

  wlf_pkg::job_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign head       = slot[rd_ptr];
  assign q_st.full  = (fill == 2'd2);
  assign q_st.empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/wlf_mul.sv =====
`timescale 1ns / 1ps
module wlf_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wlf_pkg::OPER_W-1:0]  a,
  input  logic signed [wlf_pkg::OPER_W-1:0]  b,
  output logic                               done,
  output logic signed [wlf_pkg::PROD_W-1:0]  p
);

  // Shift-and-add on magnitudes, one multiplier bit per cycle.
  logic [wlf_pkg::PROD_W-1:0] mcand, acc;
  logic [wlf_pkg::OPER_W-1:0] mplier;
  logic busy, neg;

  assign done = busy && (mplier == '0);
  assign p    = neg ? -$signed(acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= wlf_pkg::PROD_W'(a[wlf_pkg::OPER_W-1] ? -a : a);
      mplier <= b[wlf_pkg::OPER_W-1] ? -b : b;
      acc    <= '0;
      neg    <= a[wlf_pkg::OPER_W-1] ^ b[wlf_pkg::OPER_W-1];
    end else if (busy && !done) begin
      acc    <= acc + (mplier[0] ? mcand : '0);
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ===== sv/wlf_div.sv =====
`timescale 1ns / 1ps
module wlf_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wlf_pkg::PROD_W-1:0]  num,
  input  logic signed [wlf_pkg::PROD_W-1:0]  den,
  output logic                               done,
  output logic signed [wlf_pkg::OPER_W-1:0]  q
);

  // Rounded quotient num * 2^FRAC_BITS / den, ties away from zero, one bit per cycle.
  // The caller guarantees the quotient fits in QUO_W bits.
  logic [wlf_pkg::DIV_W-1:0]  rem, dsh;
  logic [wlf_pkg::QUO_W-1:0]  quo;
  logic [wlf_pkg::QCNT_W-1:0] cnt;
  logic [wlf_pkg::PROD_W-1:0] nm, dm;
  logic busy, neg;

  assign nm = wlf_pkg::abs96(num);
  assign dm = wlf_pkg::abs96(den);
  assign q  = neg ? -$signed(wlf_pkg::OPER_W'(quo)) : $signed(wlf_pkg::OPER_W'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (wlf_pkg::DIV_W'(nm) << (wlf_pkg::FRAC_BITS + 1)) + wlf_pkg::DIV_W'(dm);
      dsh <= wlf_pkg::DIV_W'(dm) << wlf_pkg::QUO_W;
      quo <= '0;
      cnt <= wlf_pkg::QCNT_W'(wlf_pkg::QUO_W - 1);
      neg <= num[wlf_pkg::PROD_W-1] ^ den[wlf_pkg::PROD_W-1];
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[wlf_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[wlf_pkg::QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/wlf_back.sv =====
`timescale 1ns / 1ps
module wlf_back (
  input  logic              clk,
  input  logic              rst,
  input  wlf_pkg::job_t     head,
  input  wlf_pkg::q_stat_t  q_st,
  output logic              q_pop,
  output logic              busy,
  wlf_result_if.source      res
);

  wlf_pkg::back_state_t state, state_next;
  wlf_pkg::job_t job_r;
  logic [2:0] step;
  logic       div_step;
  logic signed [wlf_pkg::PROD_W-1:0] p_hold, a_r, b_r, den_r, lim_r, den_mag;
  logic signed [wlf_pkg::OPER_W-1:0] mul_a, mul_b, div_q;
  logic signed [wlf_pkg::PROD_W-1:0] mul_p, div_num, div_den;
  logic [1:0] res_status;
  logic signed [wlf_pkg::SLOPE_W-1:0] res_slope;
  logic signed [wlf_pkg::OFFS_W-1:0]  res_offset;
  logic mul_start, mul_done, div_start, div_done, out_load, out_valid, limits_bad;
  logic signed [wlf_pkg::OPER_W-1:0] mean_q;

  assign den_mag    = wlf_pkg::abs96(den_r);
  assign limits_bad = (wlf_pkg::abs96(a_r) >= lim_r) ||
                      (wlf_pkg::abs96(b_r) >= (den_mag <<< wlf_pkg::OFFSET_SHIFT));
  assign busy       = (state != wlf_pkg::B_IDLE);

  always_comb begin
    case (step)
      wlf_pkg::STEP_N_SXY: begin
        mul_a = $signed(wlf_pkg::OPER_W'(job_r.n));
        mul_b = wlf_pkg::OPER_W'(job_r.sum_xy);
      end
      wlf_pkg::STEP_SX_SY: begin
        mul_a = wlf_pkg::OPER_W'(job_r.sum_x);
        mul_b = wlf_pkg::OPER_W'(job_r.sum_y);
      end
      wlf_pkg::STEP_SXX_SY: begin
        mul_a = wlf_pkg::OPER_W'(job_r.sum_xx);
        mul_b = wlf_pkg::OPER_W'(job_r.sum_y);
      end
      wlf_pkg::STEP_SX_SXY: begin
        mul_a = wlf_pkg::OPER_W'(job_r.sum_x);
        mul_b = wlf_pkg::OPER_W'(job_r.sum_xy);
      end
      wlf_pkg::STEP_N_SXX: begin
        mul_a = $signed(wlf_pkg::OPER_W'(job_r.n));
        mul_b = wlf_pkg::OPER_W'(job_r.sum_xx);
      end
      wlf_pkg::STEP_SX_SX: begin
        mul_a = wlf_pkg::OPER_W'(job_r.sum_x);
        mul_b = wlf_pkg::OPER_W'(job_r.sum_x);
      end
      default: begin
        mul_a = wlf_pkg::SLOPE_LIMIT;
        mul_b = den_mag[wlf_pkg::OPER_W-1:0];
      end
    endcase
  end

  always_comb begin
    if (job_r.avg) begin
      div_num = wlf_pkg::PROD_W'(job_r.sum_y);
      div_den = $signed(wlf_pkg::PROD_W'(job_r.n));
    end else begin
      div_num = div_step ? b_r : a_r;
      div_den = den_r;
    end
  end

  wlf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  wlf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wlf_pkg::B_IDLE: begin
        if (!q_st.empty) begin
          if (head.bad) begin
            state_next = wlf_pkg::B_FIN;
          end else if (head.avg) begin
            state_next = wlf_pkg::B_DIV_GO;
          end else begin
            state_next = wlf_pkg::B_MUL_GO;
          end
        end
      end
      wlf_pkg::B_MUL_GO: state_next = wlf_pkg::B_MUL_WAIT;
      wlf_pkg::B_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (step == wlf_pkg::STEP_LIMIT) ? wlf_pkg::B_CHECK : wlf_pkg::B_MUL_GO;
        end
      end
      wlf_pkg::B_CHECK: state_next = limits_bad ? wlf_pkg::B_FIN : wlf_pkg::B_DIV_GO;
      wlf_pkg::B_DIV_GO: state_next = wlf_pkg::B_DIV_WAIT;
      wlf_pkg::B_DIV_WAIT: begin
        if (div_done) begin
          state_next = (job_r.avg || div_step) ? wlf_pkg::B_FIN : wlf_pkg::B_DIV_GO;
        end
      end
      wlf_pkg::B_FIN: begin
        if (!out_valid || res.ready) begin
          state_next = wlf_pkg::B_IDLE;
        end
      end
      default: state_next = wlf_pkg::B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop     = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      wlf_pkg::B_IDLE:   q_pop     = !q_st.empty;
      wlf_pkg::B_MUL_GO: mul_start = 1'b1;
      wlf_pkg::B_DIV_GO: div_start = 1'b1;
      wlf_pkg::B_FIN:    out_load  = !out_valid || res.ready;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (div_q > wlf_pkg::MEAN_SAT) begin
      mean_q = wlf_pkg::MEAN_SAT;
    end else if (div_q < -wlf_pkg::MEAN_SAT) begin
      mean_q = -wlf_pkg::MEAN_SAT;
    end else begin
      mean_q = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlf_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r      <= head;
      step       <= wlf_pkg::STEP_N_SXY;
      div_step   <= 1'b0;
      res_status <= head.bad ? wlf_pkg::ST_BAD_WINDOW : wlf_pkg::ST_OK;
      res_slope  <= '0;
      res_offset <= '0;
    end
    if (state == wlf_pkg::B_MUL_WAIT && mul_done) begin
      step <= step + 1'b1;
      case (step)
        wlf_pkg::STEP_SX_SY:  a_r   <= p_hold - mul_p;
        wlf_pkg::STEP_SX_SXY: b_r   <= p_hold - mul_p;
        wlf_pkg::STEP_SX_SX:  den_r <= p_hold - mul_p;
        wlf_pkg::STEP_LIMIT:  lim_r <= mul_p;
        default:              p_hold <= mul_p;
      endcase
    end
    if (state == wlf_pkg::B_CHECK && limits_bad) begin
      res_status <= wlf_pkg::ST_OUT_OF_LIMITS;
    end
    if (state == wlf_pkg::B_DIV_WAIT && div_done) begin
      div_step <= 1'b1;
      if (job_r.avg) begin
        res_offset <= wlf_pkg::OFFS_W'(mean_q);
      end else if (div_step) begin
        res_offset <= wlf_pkg::OFFS_W'(div_q);
      end else begin
        res_slope <= wlf_pkg::SLOPE_W'(div_q);
      end
    end
    if (out_load) begin
      res.status <= res_status;
      res.slope  <= res_slope;
      res.offset <= res_offset;
    end
  end

  assign res.valid = out_valid;

endmodule

// ===== sv/windowed_line_fit_core.sv =====
`timescale 1ns / 1ps
// Windowed least-squares line fit over a stream of (x, y) samples.
// The smp channel carries one sample per transaction; last_sample closes a data set.
// Samples whose index within the set lies in [window_start, window_end] are summed.
// Each closed set yields one transaction on the res channel: status, slope, offset.
// Samples are taken one per cycle while the queue has room; the front accumulates them with two 16x16
// multipliers and passes the finished sums of a set to a two-entry queue.
// The back part works one set at a time with a bit-serial multiplier and a
// one-bit-per-cycle divider. A fit runs seven products, a limit check and,
// when the fit is within limits, two divisions for the slope and the offset;
// a fit out of limits runs no division. The average runs one division, and
// an invalid window goes straight to loading its result.
// The result waits in an output register, so the back part can work on the
// next set and the front keeps taking samples while the receiver stalls;
// smp.ready drops only when the queue holds two sets that the back part has
// not yet taken. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, which the block itself does
// not enforce. Reset (rst, synchronous) clears the sums, the queue and the valid flag
// of the result register and sets fit_mode to 1, window_start to 0 and window_end to 100.
`include "windowed_line_fit_core_assert.svh"
module windowed_line_fit_core (
  input  logic        clk,
  input  logic        rst,
  wlf_sample_if.sink  smp,
  wlf_result_if.source res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic fit_mode;
  logic [wlf_pkg::IDX_W-1:0] window_start, window_end;
  logic q_push, q_pop, bk_busy;
  wlf_pkg::job_t    push_job, head;
  wlf_pkg::q_stat_t q_st;

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= 1'b1;
      window_start <= 12'd0;
      window_end   <= 12'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        wlf_pkg::REG_FIT_MODE:     fit_mode     <= cfg_data[0];
        wlf_pkg::REG_WINDOW_START: window_start <= cfg_data;
        wlf_pkg::REG_WINDOW_END:   window_end   <= cfg_data;
        default: begin
          fit_mode <= fit_mode;
        end
      endcase
    end
  end

  // Front: index tracking, window test and running sums.
  wlf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp),
    .fit_mode     (fit_mode),
    .window_start (window_start),
    .window_end   (window_end),
    .q_st         (q_st),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // Decoupling queue between the sample stream and the arithmetic.
  wlf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .q_st     (q_st)
  );

  // Back: products, limit test, divisions and the result register.
  wlf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .q_st  (q_st),
    .q_pop (q_pop),
    .busy  (bk_busy),
    .res   (res)
  );

  `WLF_ASSERT_NOW(a_queue_no_overflow, q_push, !q_st.full, "set pushed into a full queue")
  `WLF_ASSERT_NOW(a_failed_fit_zero, res.valid && res.status != wlf_pkg::ST_OK, res.slope == '0 && res.offset == '0, "failed fit carries nonzero values")
  `WLF_ASSERT_NEXT(a_pop_starts_work, q_pop, bk_busy, "back part idle after taking a set")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT   = 20000;  // cycles without any transaction
  localparam int SETTLE_TICKS = 600;    // longer than the slowest fit
  localparam int TOTAL_ITEMS  = 750;

  typedef struct {
    wlf_pkg::fit_status_t        status;
    logic [wlf_pkg::SLOPE_W-1:0] slope;
    logic [wlf_pkg::OFFS_W-1:0]  offset;
  } fit_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;

  wlf_sample_if smp_if ();
  wlf_result_if res_if ();

  windowed_line_fit_core uut (
    .clk       (clk),
    .rst       (rst),
    .smp       (smp_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: settings and the sums of the data set in progress.
  logic       mdl_avg_mode;
  int         mdl_start;
  int         mdl_end;
  int         mdl_count;
  longint     mdl_sx, mdl_sxx, mdl_sy, mdl_sxy;

  fit_result_t expected_fits[$];
  int          error_count;
  int          items_sent;
  int          burst_left;
  int          idle_cycles;
  int          hold_request;  // set by a test; the receiver counts it down

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Rounded quotient num * 2^16 / den, ties away from zero. den must not be zero.
  function automatic longint round_quotient(input logic signed [127:0] num,
                                            input logic signed [127:0] den);
    logic        neg;
    logic [127:0] nm, dm, q;
    neg = num[127] != den[127];
    nm = num[127] ? -num : num;
    dm = den[127] ? -den : den;
    q = ((nm << (wlf_pkg::FRAC_BITS + 1)) + dm) / (dm << 1);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Adds one accepted sample to the sums if it lies in the window; a last sample
  // closes the set and queues the baseline that the block must report for it.
  function automatic void take_sample(input logic signed [15:0] x,
                                      input logic signed [15:0] y,
                                      input logic last);
    fit_result_t r;
    longint xv, yv, slope, offset;
    logic signed [127:0] n, a, b, den, dm, am, bm;
    xv = x;
    yv = y;
    if (mdl_count >= mdl_start && mdl_count <= mdl_end) begin
      mdl_sx += xv;
      mdl_sxx += xv * xv;
      mdl_sy += yv;
      mdl_sxy += xv * yv;
    end
    if (mdl_count < 4096) mdl_count++;
    if (!last) return;
    r.status = wlf_pkg::ST_OK;
    slope = 0;
    offset = 0;
    if (mdl_end >= mdl_count || mdl_end < mdl_start + 2) begin
      r.status = wlf_pkg::ST_BAD_WINDOW;
    end else begin
      n = mdl_end - mdl_start + 1;
      if (!mdl_avg_mode) begin
        a = n * 128'(mdl_sxy) - 128'(mdl_sx) * 128'(mdl_sy);
        b = 128'(mdl_sxx) * 128'(mdl_sy) - 128'(mdl_sx) * 128'(mdl_sxy);
        den = n * 128'(mdl_sxx) - 128'(mdl_sx) * 128'(mdl_sx);
        dm = den[127] ? -den : den;
        am = a[127] ? -a : a;
        bm = b[127] ? -b : b;
        if (am >= dm * 1000000 || bm >= dm * 256) begin
          r.status = wlf_pkg::ST_OUT_OF_LIMITS;
        end else begin
          slope = round_quotient(a, den);
          offset = round_quotient(b, den);
        end
      end else begin
        offset = round_quotient(128'(mdl_sy), n);
        if (offset > (64'sd256 <<< wlf_pkg::FRAC_BITS)) offset = 64'sd256 <<< wlf_pkg::FRAC_BITS;
        if (offset < -(64'sd256 <<< wlf_pkg::FRAC_BITS))
          offset = -(64'sd256 <<< wlf_pkg::FRAC_BITS);
      end
    end
    r.slope = slope[wlf_pkg::SLOPE_W-1:0];
    r.offset = offset[wlf_pkg::OFFS_W-1:0];
    expected_fits.push_back(r);
    mdl_count = 0;
    mdl_sx = 0;
    mdl_sxx = 0;
    mdl_sy = 0;
    mdl_sxy = 0;
  endfunction

  // Offers one sample and returns once the block has taken it. Valid stays high
  // between the samples of a burst; a new burst may start after a random gap.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        smp_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    smp_if.valid <= 1'b1;
    smp_if.x_value <= x;
    smp_if.y_value <= y;
    smp_if.last_sample <= last;
    do @(posedge clk); while (!smp_if.ready);
    take_sample(x, y, last);
    items_sent++;
    burst_left--;
  endtask

  // Waits until every queued result has come back and the back end is quiet.
  task automatic drain;
    smp_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles; the block must be idle.
  task automatic apply_settings(input logic avg, input int start, input int stop);
    cfg_we <= 1'b1;
    cfg_index <= wlf_pkg::REG_FIT_MODE;
    cfg_data <= {11'd0, avg};
    @(posedge clk);
    cfg_index <= wlf_pkg::REG_WINDOW_START;
    cfg_data <= start[11:0];
    @(posedge clk);
    cfg_index <= wlf_pkg::REG_WINDOW_END;
    cfg_data <= stop[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_avg_mode = avg;
    mdl_start = start;
    mdl_end = stop;
  endtask

  // Sends a whole data set. Kind 0 is a noisy line that usually fits within
  // limits, kind 1 is full-range noise, kind 2 has one repeated x value.
  task automatic send_set(input int len, input int kind);
    int i, rate, base, xs, xi;
    logic signed [15:0] x, y;
    longint yl;
    rate = int'($urandom_range(0, 100)) - 50;
    base = int'($urandom_range(0, 400)) - 200;
    xs = int'($urandom_range(0, 65535)) - 32768;
    for (i = 0; i < len; i++) begin
      case (kind)
        0: begin
          xi = int'($urandom_range(0, 1200)) - 600;
          x = xi[15:0];
          yl = longint'(rate) * longint'(xi) + longint'(base) +
               longint'(int'($urandom_range(0, 6)) - 3);
          if (yl > 32767) yl = 32767;
          if (yl < -32768) yl = -32768;
          y = yl[15:0];
        end
        1: begin
          x = 16'($urandom());
          y = 16'($urandom());
        end
        default: begin
          x = xs[15:0];
          y = 16'($urandom());
        end
      endcase
      send_sample(x, y, i == len - 1);
    end
  endtask

  // The reset settings: average over samples 0 to 100. A set of 101 samples
  // fits the window, one of 100 does not.
  task automatic test_reset_settings;
    send_set(101, 1);
    send_set(100, 0);
    drain();
  endtask

  // Field extremes and every status of the fit mode on a three-point window, then mean saturation and bad windows.
  task automatic test_corner_cases;
    apply_settings(1'b0, 0, 2);
    send_sample(-16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 1'b1);
    // All x equal: the denominator is zero, so the fit is out of limits.
    send_set(3, 2);
    // Steep line: offset past its limit.
    send_sample(16'sd0, -16'sd32768, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd2, 16'sd32767, 1'b1);
    // Window end past the last sample.
    send_set(2, 0);
    drain();
    // Mean saturates high and low.
    apply_settings(1'b1, 0, 2);
    send_set(3, 2);
    send_sample(-16'sd32768, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b1);
    send_sample(16'sd5, -16'sd32768, 1'b0);
    send_sample(16'sd5, -16'sd32768, 1'b0);
    send_sample(16'sd5, -16'sd32768, 1'b1);
    drain();
    // Window two samples wide, then start past end.
    apply_settings(1'b1, 3, 4);
    send_set(6, 0);
    drain();
    apply_settings(1'b0, 4095, 0);
    send_set(2, 0);
    drain();
  endtask

  // Random settings and sets; once the receiver holds off for a long stretch
  // while short sets keep coming, so the block must stall its input.
  task automatic test_random_sets;
    int phase, sets, len, kind, start, stop, sel;
    logic held;
    logic avg;
    held = 1'b0;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      sel = $urandom_range(0, 9);
      start = $urandom_range(0, 6);
      stop = start + int'($urandom_range(0, 30));
      if (sel == 0) begin
        start = $urandom_range(0, 4095);
        stop = $urandom_range(0, 4095);
      end else if (sel == 1) begin
        stop = 4095;
      end
      avg = (phase % 2 == 0) ? ($urandom_range(0, 1) == 1) : (phase % 4 == 1);
      apply_settings(avg, start, stop);
      if (!held && phase == 1) begin
        hold_request = 3000;
        held = 1'b1;
        for (sets = 0; sets < 8; sets++) send_set($urandom_range(1, 4), 0);
      end
      for (sets = $urandom_range(2, 6); sets > 0; sets--) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) :
              stop + 1 + int'($urandom_range(0, 4));
        if (len > 48) len = $urandom_range(1, 48);
        kind = $urandom_range(0, 9);
        send_set(len, kind < 6 ? 0 : (kind < 9 ? 1 : 2));
      end
      drain();
      phase++;
    end
  endtask

  // Result side: ready follows a randomly chosen stall pattern, with a long hold-off
  // when a test asks for one. Each result is checked here.
  int stall_mode;
  int pattern_tick;
  always @(posedge clk) begin
    fit_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_fits.size() == 0) begin
        $display("%0t: result with none expected: status %0d slope %0d offset %0d",
                 $time, res_if.status, res_if.slope, res_if.offset);
        error_count++;
      end else begin
        want = expected_fits.pop_front();
        if (res_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, res_if.status);
          error_count++;
        end
        if (res_if.slope !== want.slope) begin
          $display("%0t: slope expected %h actual %h", $time, want.slope, res_if.slope);
          error_count++;
        end
        if (res_if.offset !== want.offset) begin
          $display("%0t: offset expected %h actual %h", $time, want.offset, res_if.offset);
          error_count++;
        end
      end
    end
    pattern_tick <= pattern_tick + 1;
    if (pattern_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_request > 0) begin
      hold_request <= hold_request - 1;
      res_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 1) == 1);
        2: res_if.ready <= ($urandom_range(0, 3) == 0);
        default: res_if.ready <= (pattern_tick % 3 != 0);
      endcase
    end
  end

  // Watchdog: the run is stuck if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = wlf_pkg::REG_FIT_MODE;
    cfg_data = 12'd0;
    smp_if.valid = 1'b0;
    smp_if.x_value = 16'sd0;
    smp_if.y_value = 16'sd0;
    smp_if.last_sample = 1'b0;
    res_if.ready = 1'b0;
    error_count = 0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    hold_request = 0;
    stall_mode = 0;
    pattern_tick = 0;
    mdl_avg_mode = 1'b1;
    mdl_start = 0;
    mdl_end = 100;
    mdl_count = 0;
    mdl_sx = 0;
    mdl_sxx = 0;
    mdl_sy = 0;
    mdl_sxy = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_corner_cases();
    test_random_sets();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wlf_pkg.sv
sv/wlf_if.sv
sv/wlf_front.sv
sv/wlf_queue.sv
sv/wlf_mul.sv
sv/wlf_div.sv
sv/wlf_back.sv
sv/windowed_line_fit_core.sv
tb/tb_top.sv
